>>> rtl/dcd_pkg.sv
// dcd_pkg: shared types and constants of the disk command decoder
`default_nettype none

package dcd_pkg;

	localparam int CMD_LEN     = 6;
	localparam int IDX_W       = 3;
	localparam int CLIENT_W    = 6;
	localparam int OFFSET_W    = 21;
	localparam int SECTORS_W   = 22;
	localparam int TICKS_W     = 16;
	localparam int MASK_W      = 64;
	localparam int PADDR_W     = 5;
	localparam int PDATA_W     = 64;

	localparam logic [IDX_W-1:0] LAST_IDX = 3'(CMD_LEN - 1);

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_OPCODE = 3'd1;
	localparam logic [2:0] ST_BAD_ARG   = 3'd2;
	localparam logic [2:0] ST_BAD_DRIVE = 3'd3;
	localparam logic [2:0] ST_DATA_ERR  = 3'd4;

	localparam logic [4:0] OPC_TEST_READY = 5'h00;
	localparam logic [4:0] OPC_REZERO     = 5'h01;
	localparam logic [4:0] OPC_SENSE      = 5'h03;
	localparam logic [4:0] OPC_READ       = 5'h08;
	localparam logic [4:0] OPC_WRITE      = 5'h0a;
	localparam logic [4:0] OPC_SEEK       = 5'h0b;
	localparam logic [4:0] OPC_START_STOP = 5'h1b;

	localparam logic [1:0] REG_PRESENT = 2'd0;
	localparam logic [1:0] REG_TAPE    = 2'd1;
	localparam logic [1:0] REG_SECTORS = 2'd2;
	localparam logic [1:0] REG_TICKS   = 2'd3;

	localparam logic [TICKS_W-1:0] TICKS_RESET = 16'd100;

	typedef struct packed {
		logic       op;
		logic [7:0] data_byte;
	} cmd_t;

	typedef struct packed {
		logic [2:0]          status_code;
		logic                irq_assert;
		logic                byte_ignored;
		logic                busy_res;
		logic                transfer_start;
		logic                is_write;
		logic [CLIENT_W-1:0] target_client;
		logic [OFFSET_W-1:0] sector_offset;
		logic [7:0]          sector_count;
	} res_t;

	typedef struct packed {
		logic [MASK_W-1:0]    present_mask;
		logic [MASK_W-1:0]    tape_mask;
		logic [SECTORS_W-1:0] disk_sectors;
		logic [TICKS_W-1:0]   busy_ticks;
	} cfg_t;

endpackage

`default_nettype wire

>>> rtl/dcd_regs.sv
// dcd_regs: configuration register file behind the apb-style port
`default_nettype none

module dcd_regs
	import dcd_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready,
	output cfg_t                    cfg
);

	cfg_t        cfg_q;
	logic        wr_en;
	logic [1:0]  reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_sel = paddr[4:3];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.present_mask <= '0;
			cfg_q.tape_mask    <= '0;
			cfg_q.disk_sectors <= '0;
			cfg_q.busy_ticks   <= TICKS_RESET;
		end else if (wr_en) begin
			case (reg_sel)
				REG_PRESENT: cfg_q.present_mask <= pwdata[MASK_W-1:0];
				REG_TAPE:    cfg_q.tape_mask    <= pwdata[MASK_W-1:0];
				REG_SECTORS: cfg_q.disk_sectors <= pwdata[SECTORS_W-1:0];
				REG_TICKS:   cfg_q.busy_ticks   <= pwdata[TICKS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_PRESENT: prdata = cfg_q.present_mask;
			REG_TAPE:    prdata = cfg_q.tape_mask;
			REG_SECTORS: prdata = {{(PDATA_W-SECTORS_W){1'b0}}, cfg_q.disk_sectors};
			REG_TICKS:   prdata = {{(PDATA_W-TICKS_W){1'b0}}, cfg_q.busy_ticks};
			default:     prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/dcd_exec.sv
// dcd_exec: input register, command gather and decode, controller state, result register
`default_nettype none

module dcd_exec
	import dcd_pkg::*;
#(
	parameter int CLIENT_SLOTS = 64
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cfg_t cfg,
	input  wire logic cmd_valid,
	output logic      cmd_stall,
	input  wire cmd_t cmd,
	output logic      res_valid,
	input  wire logic res_stall,
	output res_t      res
);

	localparam logic [CLIENT_W:0] SLOTS = (CLIENT_W+1)'(CLIENT_SLOTS);
	localparam logic [MASK_W-1:0] SLOT_MASK = (CLIENT_SLOTS >= MASK_W) ? '1 :
		((MASK_W'(1) << CLIENT_SLOTS) - MASK_W'(1));

	// input stage
	logic s1_valid_q;
	cmd_t cmd_s1;

	// controller state
	logic [7:0]         cmd_bytes_q [CMD_LEN-1];
	logic [IDX_W-1:0]   byte_idx_q;
	logic               busy_q;
	logic [TICKS_W-1:0] busy_cnt_q;
	logic [2:0]         status_q;

	// result stage
	logic res_valid_q;
	res_t res_s2;

	logic advance;

	logic [IDX_W-1:0]   idx_d;
	logic               busy_d;
	logic [TICKS_W-1:0] busy_cnt_d;
	logic [2:0]         status_d;
	logic               store_byte;
	res_t               r;

	logic [7:0]           b0, b1, b2, b3, b4, b5;
	logic [4:0]           opc;
	logic [OFFSET_W-1:0]  off;
	logic [SECTORS_W-1:0] off_x;
	logic [SECTORS_W-1:0] cnt_x;
	logic [SECTORS_W-1:0] ds;
	logic [SECTORS_W-1:0] avail;
	logic [SECTORS_W-1:0] left;
	logic [CLIENT_W-1:0]  client;
	logic                 any_present;
	logic                 client_ok;
	logic                 tape;
	logic [TICKS_W-1:0]   ticks_eff;
	logic [TICKS_W-1:0]   cnt_dec;

	assign advance   = s1_valid_q & (~res_valid_q | ~res_stall);
	assign cmd_stall = s1_valid_q & ~advance;
	assign res_valid = res_valid_q;
	assign res       = res_s2;

	always_comb begin
		b0 = cmd_bytes_q[0];
		b1 = cmd_bytes_q[1];
		b2 = cmd_bytes_q[2];
		b3 = cmd_bytes_q[3];
		b4 = cmd_bytes_q[4];
		b5 = cmd_s1.data_byte;
		opc    = b0[4:0];
		off    = {b1[4:0], b2, b3};
		off_x  = {1'b0, off};
		cnt_x  = {{(SECTORS_W-8){1'b0}}, b4};
		ds     = cfg.disk_sectors;
		client = {b0[7:5], b1[7:5]};
		tape   = cfg.tape_mask[client];
		any_present = |(cfg.present_mask & SLOT_MASK);
		client_ok   = ({1'b0, client} < SLOTS) & cfg.present_mask[client];
		avail = (off_x < ds) ? (ds - off_x) : '0;
		left  = ds - off_x;
		ticks_eff = (cfg.busy_ticks == '0) ? TICKS_W'(1) : cfg.busy_ticks;
		cnt_dec   = (busy_cnt_q != '0) ? (busy_cnt_q - TICKS_W'(1)) : busy_cnt_q;

		idx_d      = byte_idx_q;
		busy_d     = busy_q;
		busy_cnt_d = busy_cnt_q;
		status_d   = status_q;
		store_byte = 1'b0;
		r          = '0;

		if (cmd_s1.op) begin
			if (busy_q) begin
				busy_cnt_d = cnt_dec;
				if (cnt_dec == '0) begin
					busy_d       = 1'b0;
					r.irq_assert = 1'b1;
				end
			end
		end else if (!any_present || busy_q) begin
			r.byte_ignored = 1'b1;
		end else if (byte_idx_q != LAST_IDX) begin
			store_byte   = 1'b1;
			idx_d        = byte_idx_q + IDX_W'(1);
			r.irq_assert = 1'b1;
		end else begin
			idx_d           = '0;
			r.target_client = client;
			if (!client_ok) begin
				status_d     = ST_BAD_DRIVE;
				r.irq_assert = 1'b1;
			end else begin
				busy_d     = 1'b1;
				busy_cnt_d = ticks_eff;
				if (b5 != 8'd0) begin
					status_d = ST_BAD_ARG;
				end else begin
					case (opc)
						OPC_TEST_READY, OPC_REZERO, OPC_SENSE, OPC_START_STOP, OPC_SEEK: begin
							status_d = ST_OK;
						end
						OPC_READ, OPC_WRITE: begin
							r.is_write = (opc == OPC_WRITE);
							if (tape) begin
								if (off == '0) begin
									status_d   = ST_DATA_ERR;
									r.is_write = 1'b0;
								end else begin
									status_d         = ST_OK;
									r.transfer_start = 1'b1;
									r.sector_offset  = off - OFFSET_W'(1);
									r.sector_count   = b4;
								end
							end else if (opc == OPC_READ) begin
								r.transfer_start = 1'b1;
								r.sector_offset  = off;
								if (cnt_x > avail) begin
									status_d       = ST_DATA_ERR;
									r.sector_count = avail[7:0];
								end else begin
									status_d       = ST_OK;
									r.sector_count = b4;
								end
							end else if (off_x > ds) begin
								status_d   = ST_DATA_ERR;
								r.is_write = 1'b0;
							end else begin
								status_d         = ST_OK;
								r.transfer_start = 1'b1;
								r.sector_offset  = off;
								r.sector_count   = ((off_x + cnt_x) > ds) ? left[7:0] : b4;
							end
						end
						default: begin
							status_d = ST_BAD_OPCODE;
						end
					endcase
				end
			end
		end

		r.status_code = status_d;
		r.busy_res    = busy_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			res_valid_q <= 1'b0;
			byte_idx_q  <= '0;
			busy_q      <= 1'b0;
			busy_cnt_q  <= '0;
			status_q    <= ST_OK;
		end else begin
			if (!cmd_stall) begin
				s1_valid_q <= cmd_valid;
			end
			if (!res_valid_q || !res_stall) begin
				res_valid_q <= s1_valid_q;
			end
			if (advance) begin
				byte_idx_q <= idx_d;
				busy_q     <= busy_d;
				busy_cnt_q <= busy_cnt_d;
				status_q   <= status_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			cmd_s1 <= cmd;
		end
		if (advance) begin
			res_s2 <= r;
		end
		if (advance && store_byte) begin
			cmd_bytes_q[byte_idx_q] <= cmd_s1.data_byte;
		end
	end

endmodule

`default_nettype wire

>>> rtl/dma_disk_command_decoder.sv
// dma_disk_command_decoder: top level of the disk command decoder
`default_nettype none

// Every beat on the cmd channel (a command byte or a time tick) yields exactly one beat on
// the res channel, in order. A beat is registered, decoded by one level of logic against the
// controller state and registered again. One beat can be accepted every cycle unless res is
// stalled; the result register lets a new beat enter while the previous result still waits.
// Six command bytes form a command; drive presence, tape flags, disk size and busy time come
// from the apb registers, which the user must write only while idle; the block does not enforce it.

module dma_disk_command_decoder
	import dcd_pkg::*;
#(
	parameter int CLIENT_SLOTS = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cmd_valid,
	output logic                    cmd_stall,
	input  wire cmd_t               cmd,
	output logic                    res_valid,
	input  wire logic               res_stall,
	output res_t                    res,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready
);

	cfg_t cfg;

	dcd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	dcd_exec #(
		.CLIENT_SLOTS (CLIENT_SLOTS)
	) u_exec (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

`ifndef SYNTH
	a_xfer_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.transfer_start |-> res.busy_res
			&& (res.status_code == ST_OK || res.status_code == ST_DATA_ERR))
		else $error("transfer without busy or with bad status");

	a_ignored_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.byte_ignored |-> !res.irq_assert && !res.transfer_start
			&& res.target_client == '0)
		else $error("dropped byte with side effects");

	a_no_xfer_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.transfer_start |-> !res.is_write
			&& res.sector_offset == '0 && res.sector_count == '0)
		else $error("transfer fields set without transfer");
`endif

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
// tb: self-checking testbench of the disk command decoder with its own decode predictor
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import dcd_pkg::*;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;
	localparam int BOOT_ROWS = 2;
	localparam int PHASES = 7;
	localparam int TICK_CAP = 64;
	localparam int WATCHDOG_LIMIT = 2000;

	typedef struct {
		cmd_t beat;
		bit   pinned;
		res_t want;
	} stim_row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cmd_valid = 1'b0;
	logic                cmd_stall;
	cmd_t                cmd = '0;
	logic                res_valid;
	logic                res_stall = 1'b0;
	res_t                res;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [PADDR_W-1:0]  paddr = '0;
	logic [PDATA_W-1:0]  pwdata = '0;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	// decoder image
	logic [7:0]           cmd_buf [CMD_LEN];
	logic [IDX_W-1:0]     byte_pos = '0;
	logic                 busy = 1'b0;
	logic [TICKS_W-1:0]   busy_left = '0;
	logic [2:0]           status = ST_OK;
	logic [MASK_W-1:0]    drive_map = '0;
	logic [MASK_W-1:0]    tape_map = '0;
	logic [SECTORS_W-1:0] disk_size = '0;
	logic [TICKS_W-1:0]   busy_len = TICKS_RESET;

	res_t      due_results [$];
	stim_row_t script [$];
	int        useful_beats = 0;
	int        results_seen = 0;
	int        fails = 0;
	int        quiet_cycles = 0;
	bit        sender_calm = 1'b0;
	bit        receiver_calm = 1'b0;

	dma_disk_command_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #5 clk = ~clk;

	function automatic res_t decode_beat(cmd_t c);
		res_t        r;
		logic [5:0]  client;
		logic [4:0]  opc;
		int unsigned off, cnt, room;
		bit          moved;
		r = '0;
		if (c.op == OP_TICK) begin
			if (busy) begin
				if (busy_left != 0) busy_left--;
				if (busy_left == 0) begin
					busy = 1'b0;
					r.irq_assert = 1'b1;
				end
			end
		end else if (drive_map == '0 || busy) begin
			r.byte_ignored = 1'b1;
		end else begin
			cmd_buf[byte_pos] = c.data_byte;
			if (byte_pos != LAST_IDX) begin
				byte_pos++;
				r.irq_assert = 1'b1;
			end else begin
				byte_pos = '0;
				client = {cmd_buf[0][7:5], cmd_buf[1][7:5]};
				opc = cmd_buf[0][4:0];
				off = 32'({cmd_buf[1][4:0], cmd_buf[2], cmd_buf[3]});
				cnt = 32'(cmd_buf[4]);
				moved = 1'b0;
				r.target_client = client;
				if (!drive_map[client]) begin
					status = ST_BAD_DRIVE;
					r.irq_assert = 1'b1;
				end else begin
					if (cmd_buf[5] != 8'h00) begin
						status = ST_BAD_ARG;
					end else begin
						case (opc)
						OPC_TEST_READY, OPC_REZERO, OPC_SENSE, OPC_SEEK, OPC_START_STOP: begin
							status = ST_OK;
						end
						OPC_READ, OPC_WRITE: begin
							moved = 1'b1;
							status = ST_OK;
							if (tape_map[client]) begin
								// tape blocks count from one
								if (off == 0) begin
									status = ST_DATA_ERR;
									moved = 1'b0;
								end else begin
									off--;
								end
							end else if (opc == OPC_READ) begin
								room = (off < disk_size) ? 32'(disk_size) - off : 0;
								if (cnt > room) begin
									cnt = room;
									status = ST_DATA_ERR;
								end
							end else if (off > disk_size) begin
								status = ST_DATA_ERR;
								moved = 1'b0;
							end else if (off + cnt > disk_size) begin
								cnt = 32'(disk_size) - off;
							end
						end
						default: begin
							status = ST_BAD_OPCODE;
						end
						endcase
					end
					busy = 1'b1;
					busy_left = (busy_len != 0) ? busy_len : TICKS_W'(1);
					if (moved) begin
						r.transfer_start = 1'b1;
						r.is_write = (opc == OPC_WRITE);
						r.sector_offset = off[OFFSET_W-1:0];
						r.sector_count = cnt[7:0];
					end
				end
			end
		end
		r.status_code = status;
		r.busy_res = busy;
		return r;
	endfunction

	function automatic res_t outcome(logic [2:0] st, int irq, int ign, int bsy,
			int xfer, int wr, int client, int off, int cnt);
		res_t r;
		r.status_code = st;
		r.irq_assert = 1'(irq);
		r.byte_ignored = 1'(ign);
		r.busy_res = 1'(bsy);
		r.transfer_start = 1'(xfer);
		r.is_write = 1'(wr);
		r.target_client = CLIENT_W'(client);
		r.sector_offset = OFFSET_W'(off);
		r.sector_count = 8'(cnt);
		return r;
	endfunction

	function automatic void row(logic op, logic [7:0] b, bit pinned = 1'b0, res_t want = '0);
		stim_row_t s;
		s.beat = {op, b};
		s.pinned = pinned;
		s.want = want;
		script.push_back(s);
	endfunction

	function automatic string show(res_t r);
		return $sformatf("st=%0d irq=%0d ign=%0d busy=%0d xfer=%0d wr=%0d client=%0d off=%0d cnt=%0d",
			r.status_code, r.irq_assert, r.byte_ignored, r.busy_res, r.transfer_start,
			r.is_write, r.target_client, r.sector_offset, r.sector_count);
	endfunction

	task automatic check_result(res_t got);
		res_t want;
		results_seen++;
		if (due_results.size() == 0) begin
			fails++;
			if (fails <= 10) $display("result %0d arrived with nothing due: %s", results_seen,
				show(got));
			return;
		end
		want = due_results.pop_front();
		if (got.status_code !== want.status_code || got.irq_assert !== want.irq_assert
				|| got.byte_ignored !== want.byte_ignored || got.busy_res !== want.busy_res
				|| got.transfer_start !== want.transfer_start || got.is_write !== want.is_write
				|| got.target_client !== want.target_client
				|| got.sector_offset !== want.sector_offset
				|| got.sector_count !== want.sector_count) begin
			fails++;
			if (fails <= 10) begin
				$display("result %0d mismatch", results_seen);
				$display("  expected %s", show(want));
				$display("  actual   %s", show(got));
			end
		end
	endtask

	task automatic send_beat(cmd_t beat, bit pinned = 1'b0, res_t want = '0);
		int   gap;
		res_t guess;
		gap = sender_calm ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= beat;
		do @(posedge clk); while (cmd_stall !== 1'b0);
		guess = decode_beat(beat);
		due_results.push_back(pinned ? want : guess);
		if (!guess.byte_ignored) useful_beats++;
	endtask

	task automatic await_idle();
		cmd_valid <= 1'b0;
		do @(posedge clk); while (due_results.size() != 0);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [PDATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
	endtask

	task automatic configure(logic [MASK_W-1:0] present, logic [MASK_W-1:0] tape,
			logic [SECTORS_W-1:0] sectors, logic [TICKS_W-1:0] ticks);
		await_idle();
		write_reg(REG_PRESENT, present);
		write_reg(REG_TAPE, tape);
		write_reg(REG_SECTORS, PDATA_W'(sectors));
		write_reg(REG_TICKS, PDATA_W'(ticks));
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		drive_map = present;
		tape_map = tape;
		disk_size = sectors;
		busy_len = ticks;
	endtask

	// finish any partial frame, wait out busy, then one six-byte command and its ticks
	task automatic run_command();
		logic [7:0]          frame [CMD_LEN];
		logic [CLIENT_W-1:0] client;
		logic [4:0]          opc;
		int unsigned         off, cnt;
		int                  n;
		while (byte_pos != '0) send_beat({OP_BYTE, 8'($urandom)});
		for (n = 0; busy && n < TICK_CAP; n++) send_beat({OP_TICK, 8'($urandom)});
		if (busy) return;
		if ($urandom_range(0, 4) == 0) begin
			client = CLIENT_W'($urandom);
		end else begin
			do client = CLIENT_W'($urandom); while (!drive_map[client]);
		end
		case ($urandom_range(0, 9))
		0, 1, 2, 3: opc = OPC_READ;
		4, 5, 6, 7: opc = OPC_WRITE;
		8: begin
			case ($urandom_range(0, 4))
			0: opc = OPC_TEST_READY;
			1: opc = OPC_REZERO;
			2: opc = OPC_SENSE;
			3: opc = OPC_SEEK;
			default: opc = OPC_START_STOP;
			endcase
		end
		default: opc = 5'($urandom);
		endcase
		case ($urandom_range(0, 3))
		0: cnt = 0;
		1: cnt = 255;
		default: cnt = $urandom_range(0, 255);
		endcase
		// offsets cluster around the end of the disk
		case ($urandom_range(0, 5))
		0: off = 0;
		1: off = 1;
		2: off = disk_size - cnt + $urandom_range(0, 2) - 1;
		3: off = disk_size + $urandom_range(0, 2) - 1;
		default: off = $urandom;
		endcase
		off &= 32'h001F_FFFF;
		frame[0] = {client[5:3], opc};
		frame[1] = {client[2:0], off[20:16]};
		frame[2] = off[15:8];
		frame[3] = off[7:0];
		frame[4] = cnt[7:0];
		frame[5] = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
		for (n = 0; n < CMD_LEN; n++) begin
			if ($urandom_range(0, 15) == 0) send_beat({OP_TICK, 8'($urandom)});
			send_beat({OP_BYTE, frame[n]});
		end
		for (n = 0; busy && n < TICK_CAP; n++) begin
			if ($urandom_range(0, 7) == 0) send_beat({OP_BYTE, 8'($urandom)});
			send_beat({OP_TICK, 8'($urandom)});
		end
	endtask

	always @(posedge clk) begin
		if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall)) quiet_cycles <= 0;
		else if (arst_n) quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= WATCHDOG_LIMIT);
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		int hold;
		wait (arst_n);
		forever begin
			hold = receiver_calm ? 0 : $urandom_range(0, 15);
			if (hold > 0) begin
				res_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			res_stall <= 1'b0;
			do @(posedge clk); while (res_valid !== 1'b1);
			check_result(res);
		end
	end

	initial begin
		int phase, goal, pick;
		foreach (cmd_buf[i]) cmd_buf[i] = 8'h00;

		// out of reset: no drive attached
		row(OP_TICK, 8'h00, 1'b1, outcome(ST_OK, 0, 0, 0, 0, 0, 0, 0, 0));
		row(OP_BYTE, 8'hFF, 1'b1, outcome(ST_OK, 0, 1, 0, 0, 0, 0, 0, 0));
		// disk read running past the end, byte while busy, tick to done
		row(OP_BYTE, 8'(OPC_READ), 1'b1, outcome(ST_OK, 1, 0, 0, 0, 0, 0, 0, 0));
		row(OP_BYTE, 8'h00);
		row(OP_BYTE, 8'h00);
		row(OP_BYTE, 8'd90);
		row(OP_BYTE, 8'd20);
		row(OP_BYTE, 8'h00, 1'b1, outcome(ST_DATA_ERR, 0, 0, 1, 1, 0, 0, 90, 10));
		row(OP_BYTE, 8'h00, 1'b1, outcome(ST_DATA_ERR, 0, 1, 1, 0, 0, 0, 0, 0));
		row(OP_TICK, 8'h00, 1'b1, outcome(ST_DATA_ERR, 1, 0, 0, 0, 0, 0, 0, 0));
		// tape write at block zero
		row(OP_BYTE, 8'(OPC_WRITE));
		row(OP_BYTE, 8'h20);
		row(OP_BYTE, 8'h00);
		row(OP_BYTE, 8'h00);
		row(OP_BYTE, 8'h05);
		row(OP_BYTE, 8'h00, 1'b1, outcome(ST_DATA_ERR, 0, 0, 1, 0, 0, 1, 0, 0));
		row(OP_TICK, 8'hFF);
		// absent drive at controller 7 device 6
		row(OP_BYTE, 8'hE8);
		row(OP_BYTE, 8'hC0);
		row(OP_BYTE, 8'h00);
		row(OP_BYTE, 8'h00);
		row(OP_BYTE, 8'h01);
		row(OP_BYTE, 8'h00, 1'b1, outcome(ST_BAD_DRIVE, 1, 0, 0, 0, 0, 62, 0, 0));
		// all ones: last slot, non-zero control byte
		repeat (5) row(OP_BYTE, 8'hFF);
		row(OP_BYTE, 8'hFF, 1'b1, outcome(ST_BAD_ARG, 0, 0, 1, 0, 0, 63, 0, 0));
		row(OP_TICK, 8'hFF);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		foreach (script[i]) begin
			if (i == BOOT_ROWS) configure(64'h8000_0000_0000_0003, 64'h2, 22'd100, 16'd1);
			send_beat(script[i].beat, script[i].pinned, script[i].want);
		end

		for (phase = 0; phase < PHASES; phase++) begin
			case (phase)
			0: configure('1, '0, 22'd2097152, 16'd1);
			1: configure({$urandom, $urandom} | 64'h1, {$urandom, $urandom},
				SECTORS_W'($urandom_range(0, 400)), TICKS_W'($urandom_range(1, 6)));
			2: configure('0, {$urandom, $urandom}, SECTORS_W'($urandom_range(0, 2097152)),
				16'd3);
			3: configure({$urandom, $urandom} | (64'h1 << $urandom_range(0, 63)), '1, 22'd0,
				TICKS_W'($urandom_range(1, 4)));
			4: configure(64'h1 << $urandom_range(0, 63), '0,
				SECTORS_W'($urandom_range(0, 2097152)), TICKS_W'($urandom_range(1, 8)));
			5: configure({$urandom, $urandom}, {$urandom, $urandom},
				SECTORS_W'($urandom_range(0, 2000)), TICKS_W'($urandom_range(1, 12)));
			default: configure('1, {$urandom, $urandom}, 22'd500, 16'hFFFF);
			endcase
			sender_calm = ($urandom_range(0, 3) == 0);
			receiver_calm = ($urandom_range(0, 3) == 0);
			goal = useful_beats + ((phase == 2 || phase == PHASES - 1) ? 50 : 210);
			while (useful_beats < goal) begin
				pick = $urandom_range(0, 99);
				if (pick < 2) await_idle();
				else if (pick < 75 && drive_map != '0 && !busy) run_command();
				else send_beat({1'($urandom), 8'($urandom)});
			end
		end

		await_idle();
		repeat (8) @(posedge clk);
		if (fails == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

>>> dma_disk_command_decoder.f
rtl/dcd_pkg.sv
rtl/dcd_regs.sv
rtl/dcd_exec.sv
rtl/dma_disk_command_decoder.sv
tb/sv/tb.sv
